### rtl/pxu3_pkg.sv
// ----------------------------------------------------------------------------
// pxu3_pkg
// Shared types and constants of the 3x pixel-art upscaler.
// ----------------------------------------------------------------------------
package pxu3_pkg;

  localparam int PIX_W     = 8;   // indexed pixel
  localparam int CFG_W     = 11;  // configuration register data
  localparam int CFG_IDX_W = 1;   // configuration register index
  localparam int POS_W     = 10;  // src_col / src_row on the result word

  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 1024;
  localparam int IMAGE_WIDTH_RESET  = 320;
  localparam int IMAGE_HEIGHT_RESET = 200;

  // Result queue between front and back; depth must be a power of two.
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  // One window column, index 0 = top, 1 = mid, 2 = bottom.
  typedef pix_t [2:0] wcol_t;
  // Window, index 0 = left, 1 = center, 2 = right.
  typedef wcol_t [2:0] window_t;

  typedef struct packed {
    window_t          win;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } q_entry_t;

  // Up to two blocks per cycle from the front; e0 goes in first.
  typedef struct packed {
    logic [1:0] cnt;
    q_entry_t   e0;
    q_entry_t   e1;
  } q_push_t;

endpackage

### rtl/pxu3_if.sv
// ----------------------------------------------------------------------------
// pxu3_if
// Channel interfaces: source pixel words, result blocks, register writes.
// ----------------------------------------------------------------------------
interface pxu3_pix_if import pxu3_pkg::*;;
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, command, pixel, input ready);
  modport sink   (input valid, command, pixel, output ready);
endinterface

interface pxu3_blk_if import pxu3_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_top_left;
  logic [PIX_W-1:0] out_top_mid;
  logic [PIX_W-1:0] out_top_right;
  logic [PIX_W-1:0] out_mid_left;
  logic [PIX_W-1:0] out_center;
  logic [PIX_W-1:0] out_mid_right;
  logic [PIX_W-1:0] out_bot_left;
  logic [PIX_W-1:0] out_bot_mid;
  logic [PIX_W-1:0] out_bot_right;
  logic [POS_W-1:0] src_col;
  logic [POS_W-1:0] src_row;
  logic             run_last;

  modport source (output valid, out_top_left, out_top_mid, out_top_right, out_mid_left,
                  out_center, out_mid_right, out_bot_left, out_bot_mid, out_bot_right,
                  src_col, src_row, run_last, input ready);
  modport sink   (input valid, out_top_left, out_top_mid, out_top_right, out_mid_left,
                  out_center, out_mid_right, out_bot_left, out_bot_mid, out_bot_right,
                  src_col, src_row, run_last, output ready);
endinterface

interface pxu3_cfg_if import pxu3_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pxu3_ram.sv
// ----------------------------------------------------------------------------
// pxu3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pxu3_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/pxu3_front.sv
// ----------------------------------------------------------------------------
// pxu3_front
// Register file, raster counters, line buffers and 3x3 window; classifies
// each word and pushes zero, one or two blocks into the result queue.
// ----------------------------------------------------------------------------
module pxu3_front import pxu3_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEFAULT,
  parameter int MaxHeight = MAX_HEIGHT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pxu3_pix_if.sink          pix_i,
  pxu3_cfg_if.sink          cfg_i,
  input  logic [QCNT_W-1:0] q_free_i,
  output q_push_t           push_o
);

  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight + 1);
  localparam int WCmpW = ($clog2(MaxWidth + 1) > CFG_W) ? $clog2(MaxWidth + 1) : CFG_W;
  localparam int HCmpW = ($clog2(MaxHeight + 1) > CFG_W) ? $clog2(MaxHeight + 1) : CFG_W;
  localparam int WidthLastRst =
    ((IMAGE_WIDTH_RESET > MaxWidth) ? MaxWidth : IMAGE_WIDTH_RESET) - 1;
  localparam int HeightRst =
    (IMAGE_HEIGHT_RESET > MaxHeight) ? MaxHeight : IMAGE_HEIGHT_RESET;

  // Configuration, held already clamped
  logic [ColW-1:0]  width_last_q, width_last_d;
  logic [RowW-1:0]  height_q, height_d;
  logic [WCmpW-1:0] wdat_ext;
  logic [HCmpW-1:0] hdat_ext;
  logic             cfg_we;

  // Raster counters and accept stage
  logic [ColW-1:0] col_count_q;
  logic [RowW-1:0] row_count_q;
  logic [ColW-1:0] col_sel;
  logic            at_last;
  logic            accept;

  // Work stage: one word per cycle while words are admitted, line buffer data arrives here
  logic                b_valid_q;
  logic [ColW-1:0]     b_col_q;
  logic [RowW-1:0]     b_row_q;
  logic                b_last_q;
  logic                b_drain_q;
  pix_t                b_pixel_q;
  logic                b_fwd_q;
  logic [2*PIX_W-1:0]  b_fwd_data_q;

  logic [2*PIX_W-1:0]  ram_rdata;
  logic [2*PIX_W-1:0]  line_word;
  logic [2*PIX_W-1:0]  wr_data;
  pix_t                top, mid, bot;
  wcol_t               new_col;
  window_t             win_q, win_d, win1, win2;
  logic                emit, emit0, emit1;
  logic [RowW-1:0]     src_row;
  logic [ColW-1:0]     col_m1;
  q_entry_t            blk0, blk1;

  // ---------------- register writes ----------------
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign wdat_ext    = WCmpW'(cfg_i.data);
  assign hdat_ext    = HCmpW'(cfg_i.data);

  always_comb begin
    width_last_d = width_last_q;
    height_d     = height_q;
    case (cfg_i.index)
      CFG_IMAGE_WIDTH: begin
        if (wdat_ext == '0) begin
          width_last_d = '0;
        end else if (wdat_ext > WCmpW'(MaxWidth)) begin
          width_last_d = ColW'(MaxWidth - 1);
        end else begin
          width_last_d = ColW'(wdat_ext - WCmpW'(1));
        end
      end
      CFG_IMAGE_HEIGHT: begin
        if (hdat_ext == '0) begin
          height_d = RowW'(1);
        end else if (hdat_ext > HCmpW'(MaxHeight)) begin
          height_d = RowW'(MaxHeight);
        end else begin
          height_d = RowW'(hdat_ext);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q <= ColW'(WidthLastRst);
      height_q     <= RowW'(HeightRst);
    end else if (cfg_we) begin
      width_last_q <= width_last_d;
      height_q     <= height_d;
    end
  end

  // ---------------- accept stage ----------------
  // Admit a word only if the queue still has room for its two blocks
  // after what the work stage pushes this cycle.
  assign pix_i.ready = (q_free_i >= (QCNT_W'(push_o.cnt) + QCNT_W'(2)));
  assign accept      = pix_i.valid && pix_i.ready;

  // A column at or beyond the width counts as the last one.
  assign col_sel = (col_count_q > width_last_q) ? width_last_q : col_count_q;
  assign at_last = (col_sel == width_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      b_valid_q   <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        if (at_last) begin
          col_count_q <= '0;
          row_count_q <= (row_count_q >= height_q) ? '0 : row_count_q + RowW'(1);
        end else begin
          col_count_q <= col_sel + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q      <= col_sel;
      b_row_q      <= row_count_q;
      b_last_q     <= at_last;
      b_drain_q    <= (pix_i.command == CMD_DRAIN);
      b_pixel_q    <= pix_i.pixel;
      // The read issued now misses the write of the word ahead of it.
      b_fwd_q      <= b_valid_q && (b_col_q == col_sel);
      b_fwd_data_q <= wr_data;
    end
  end

  // Both line buffers share one word: {two rows above, one row above}.
  pxu3_ram #(
    .Width (2*PIX_W),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (col_sel),
    .rdata_o (ram_rdata)
  );

  // ---------------- work stage ----------------
  always_comb begin
    line_word = b_fwd_q ? b_fwd_data_q : ram_rdata;
    mid       = line_word[PIX_W-1:0];
    top       = (b_row_q <= RowW'(1)) ? mid : line_word[2*PIX_W-1:PIX_W];
    bot       = b_drain_q ? mid : b_pixel_q;
    wr_data   = {mid, bot};
    new_col   = {bot, mid, top};

    // Left edge fills the whole window with the first column.
    win1 = (b_col_q == '0) ? {new_col, new_col, new_col} : {new_col, win_q[2], win_q[1]};
    // Right edge repeats the last column once more.
    win2 = {new_col, win1[2], win1[1]};

    emit  = (b_row_q != '0);
    emit0 = b_valid_q && emit && (b_col_q != '0);
    emit1 = b_valid_q && emit && b_last_q;
    win_d = emit1 ? win2 : win1;

    src_row = b_row_q - RowW'(1);
    col_m1  = b_col_q - ColW'(1);

    blk0.win  = win1;
    blk0.col  = POS_W'(col_m1);
    blk0.row  = POS_W'(src_row);
    blk0.last = !emit1;
    blk1.win  = win2;
    blk1.col  = POS_W'(b_col_q);
    blk1.row  = POS_W'(src_row);
    blk1.last = 1'b1;

    push_o.cnt = {1'b0, emit0} + {1'b0, emit1};
    push_o.e0  = emit0 ? blk0 : blk1;
    push_o.e1  = blk1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (b_valid_q) begin
      win_q <= win_d;
    end
  end

endmodule

### rtl/pxu3_queue.sv
// ----------------------------------------------------------------------------
// pxu3_queue
// Short block queue between front and back; two pushes, one pop per cycle.
// ----------------------------------------------------------------------------
module pxu3_queue import pxu3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_push_t           push_i,
  output logic [QCNT_W-1:0] free_o,
  output logic              head_valid_o,
  output q_entry_t          head_o,
  input  logic              pop_i
);

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              pop;

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign free_o       = QCNT_W'(QDEPTH) - count_q;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i.cnt) - QCNT_W'(pop);
    end
  end

endmodule

### rtl/pxu3_back.sv
// ----------------------------------------------------------------------------
// pxu3_back
// Applies the Scale3x rules to a queued window and holds the result word.
// ----------------------------------------------------------------------------
module pxu3_back import pxu3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  q_entry_t  head_i,
  output logic      pop_o,
  pxu3_blk_if.source blk_o
);

  logic             out_valid_q;
  logic [8:0][PIX_W-1:0] res;

  function automatic logic [8:0][PIX_W-1:0] scale3x(input window_t w);
    pix_t a, b, c, d, e, f, g, h, k;
    logic ul, ur, dl, dr;
    logic [8:0][PIX_W-1:0] o;
    a = w[0][0]; d = w[0][1]; g = w[0][2];
    b = w[1][0]; e = w[1][1]; h = w[1][2];
    c = w[2][0]; f = w[2][1]; k = w[2][2];
    ul = (d == b) && (b != f) && (d != h);
    ur = (b == f) && (b != d) && (f != h);
    dl = (d == h) && (d != b) && (h != f);
    dr = (h == f) && (d != h) && (b != f);
    o[0] = ul ? d : e;
    o[1] = ((ul && e != c) || (ur && e != a)) ? b : e;
    o[2] = ur ? f : e;
    o[3] = ((ul && e != g) || (dl && e != a)) ? d : e;
    o[4] = e;
    o[5] = ((ur && e != k) || (dr && e != c)) ? f : e;
    o[6] = dl ? d : e;
    o[7] = ((dl && e != k) || (dr && e != g)) ? h : e;
    o[8] = dr ? f : e;
    return o;
  endfunction

  assign res         = scale3x(head_i.win);
  // Take the next block whenever the output register is empty or drains.
  assign pop_o       = head_valid_i && (!out_valid_q || blk_o.ready);
  assign blk_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || blk_o.ready) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      blk_o.out_top_left  <= res[0];
      blk_o.out_top_mid   <= res[1];
      blk_o.out_top_right <= res[2];
      blk_o.out_mid_left  <= res[3];
      blk_o.out_center    <= res[4];
      blk_o.out_mid_right <= res[5];
      blk_o.out_bot_left  <= res[6];
      blk_o.out_bot_mid   <= res[7];
      blk_o.out_bot_right <= res[8];
      blk_o.src_col       <= head_i.col;
      blk_o.src_row       <= head_i.row;
      blk_o.run_last      <= head_i.last;
    end
  end

endmodule

### rtl/pixel_art_upscale_3x.sv
// The word completing a block is registered into the work stage (line buffer
//   read); its blocks enter the queue and the rules result is registered for
//   output. Throughput: one pixel word per cycle; past row zero a last-column
//   word yields up to two blocks, and the 8-entry queue pauses input when
//   short of room for two more blocks. Reset: clears counters, window, queue
//   and output valid, restores 320x200; line buffers are not cleared.
// ----------------------------------------------------------------------------
// pixel_art_upscale_3x
// Streaming Scale3x upscaler: each source pixel becomes a 3x3 block of output
// pixels, edge neighbours clamped, final row flushed by drain words.
// ----------------------------------------------------------------------------
module pixel_art_upscale_3x import pxu3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pxu3_pix_if.sink   pix_i,
  pxu3_cfg_if.sink   cfg_i,
  pxu3_blk_if.source blk_o
);

  // Front to queue: up to two classified blocks per cycle
  q_push_t           push;
  logic [QCNT_W-1:0] q_free;

  // Queue to back: head block and its take strobe
  logic              head_valid;
  q_entry_t          head;
  logic              pop;

  // Front: register writes, raster position, line buffers and the window.
  // Each pixel word loads one window column; once a row is behind us, it
  // emits the block left of it, and at the row end also the edge block.
  pxu3_front #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_i),
    .q_free_i (q_free),
    .push_o   (push)
  );

  // Decouple the bursty front (two blocks at row ends) from the back.
  pxu3_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .free_o       (q_free),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back: compare-and-select rules into the output register.
  pxu3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .blk_o        (blk_o)
  );

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x pixel-art upscaler. Pixel and drain
// words go in through the pixel channel, and the geometry registers are
// written through the register channel while the block is idle. Every result
// block is checked field by field against an in-bench Scale3x predictor that
// tracks line buffers, window and raster position. Directed frames hit the
// edge clamps, early drains, pixels in the drain row, mid-row width shrink,
// a height cut below the current row and out-of-range registers. Random
// frames with small palettes follow, with random gaps on both sides and one
// long receiver stall.
// ----------------------------------------------------------------------------
module tb_top import pxu3_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = MAX_WIDTH_DEFAULT;
  localparam int MAX_H = MAX_HEIGHT_DEFAULT;

  // One expected or observed 3x3 output block with its position tags.
  typedef struct {
    pix_t             px [9];
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } blk_t;

  // --------------------------------------------------------------------------
  // Scoreboard: Scale3x predictor plus the queue of blocks still owed.
  // --------------------------------------------------------------------------
  class upscale_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             near_line [MAX_W];  // row just above the current one
    pix_t             far_line  [MAX_W];  // row two above
    pix_t             win [3][3];         // [left/center/right][top/mid/bottom]
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    blk_t             pending_blocks [$];
    int unsigned      mismatches;
    string            names [9];

    function new();
      width_reg  = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      foreach (near_line[k]) begin
        near_line[k] = '0;
        far_line[k]  = '0;
      end
      foreach (win[k, j]) win[k][j] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mismatches = 0;
      names = '{"out_top_left", "out_top_mid", "out_top_right",
                "out_mid_left", "out_center", "out_mid_right",
                "out_bot_left", "out_bot_mid", "out_bot_right"};
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols();
      return clamp_dim(width_reg, MAX_W);
    endfunction

    function int unsigned rows();
      return clamp_dim(height_reg, MAX_H);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = val;
        CFG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function void shift_column(pix_t top, pix_t mid, pix_t bot);
      win[0] = win[1];
      win[1] = win[2];
      win[2] = '{top, mid, bot};
    endfunction

    // Apply the Scale3x rules to the current window.
    function blk_t scale3x_block(int unsigned col, int unsigned row);
      blk_t o;
      pix_t a, b, c, d, e, f, g, h, i;
      bit   ul, ur, dl, dr;
      a = win[0][0]; d = win[0][1]; g = win[0][2];
      b = win[1][0]; e = win[1][1]; h = win[1][2];
      c = win[2][0]; f = win[2][1]; i = win[2][2];
      ul = (d == b) && (b != f) && (d != h);
      ur = (b == f) && (b != d) && (f != h);
      dl = (d == h) && (d != b) && (h != f);
      dr = (h == f) && (d != h) && (b != f);
      o.px[0] = ul ? d : e;
      o.px[1] = ((ul && e != c) || (ur && e != a)) ? b : e;
      o.px[2] = ur ? f : e;
      o.px[3] = ((ul && e != g) || (dl && e != a)) ? d : e;
      o.px[4] = e;
      o.px[5] = ((ur && e != i) || (dr && e != c)) ? f : e;
      o.px[6] = dl ? d : e;
      o.px[7] = ((dl && e != i) || (dr && e != g)) ? h : e;
      o.px[8] = dr ? f : e;
      o.col   = POS_W'(col);
      o.row   = POS_W'(row);
      o.last  = 1'b0;
      return o;
    endfunction

    // Advance the predictor by one accepted word and queue the blocks it owes.
    function void note_word(cmd_e cmd, pix_t px);
      int unsigned w, h, c;
      pix_t        top, mid, bot;
      blk_t        made [$];
      w = cols();
      h = rows();
      c = col_cnt;
      if (c >= w) c = w - 1;
      mid = near_line[c];
      top = (row_cnt <= 1) ? mid : far_line[c];
      bot = (cmd == CMD_DRAIN) ? mid : px;
      far_line[c]  = mid;
      near_line[c] = bot;
      if (c == 0) begin
        win[0] = '{top, mid, bot};
        win[1] = win[0];
        win[2] = win[0];
      end else begin
        shift_column(top, mid, bot);
      end
      if (row_cnt >= 1) begin
        if (c >= 1) made.push_back(scale3x_block(c - 1, row_cnt - 1));
        if (c == w - 1) begin
          shift_column(top, mid, bot);
          made.push_back(scale3x_block(c, row_cnt - 1));
        end
        if (made.size() > 0) made[made.size() - 1].last = 1'b1;
        foreach (made[k]) pending_blocks.push_back(made[k]);
      end
      if (c >= w - 1) begin
        col_cnt = 0;
        row_cnt = (row_cnt >= h) ? 0 : row_cnt + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("%0t: MISMATCH %s", $time, what);
    endtask

    task check_block(blk_t got);
      blk_t want;
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected block at col %0d row %0d",
                                  got.col, got.row));
        return;
      end
      want = pending_blocks.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got.px[k] !== want.px[k])
          report_mismatch($sformatf("%s got %0h exp %0h (col %0d row %0d)",
                                    names[k], got.px[k], want.px[k], want.col, want.row));
      end
      if (got.col !== want.col)
        report_mismatch($sformatf("src_col got %0d exp %0d", got.col, want.col));
      if (got.row !== want.row)
        report_mismatch($sformatf("src_row got %0d exp %0d", got.row, want.row));
      if (got.last !== want.last)
        report_mismatch($sformatf("run_last got %0b exp %0b (col %0d row %0d)",
                                  got.last, want.last, want.col, want.row));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pxu3_pix_if pix_if ();
  pxu3_cfg_if cfg_if ();
  pxu3_blk_if blk_if ();

  pixel_art_upscale_3x i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .blk_o  (blk_if)
  );

  upscale_scoreboard sb = new();

  int          idle_pct   = 30;  // chance in a hundred that a side idles instead of acting
  int unsigned words_sent = 0;
  bit          press_arm  = 1'b0;
  bit          rx_hold;

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one word; valid stays high after acceptance so back-to-back words
  // never see valid lowered and raised in the same step.
  task automatic send_word(cmd_e cmd, pix_t px);
    while ($urandom_range(99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.command <= cmd;
    pix_if.pixel   <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_word(cmd, px);
    words_sent++;
  endtask

  // Drop the pixel stream, drain every owed block, then let the pipeline go
  // quiet so words that owe nothing have left the block too.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stream one whole frame at the current geometry, drain row included.
  // Pixels come mostly from a small palette so the corner rules fire;
  // noise_pct mixes in early drains and pixels in the drain row.
  task automatic run_frame(int noise_pct);
    int unsigned w, h, pal_n;
    pix_t        pal [4];
    cmd_e        cmd;
    pix_t        px;
    w = sb.cols();
    h = sb.rows();
    pal_n = $urandom_range(4, 2);
    foreach (pal[k]) pal[k] = pix_t'($urandom);
    for (int r = 0; r <= int'(h); r++) begin
      for (int c = 0; c < int'(w); c++) begin
        if (r == int'(h))
          cmd = ($urandom_range(99) < noise_pct) ? CMD_PIXEL : CMD_DRAIN;
        else if (r >= 1 && $urandom_range(99) < noise_pct)
          cmd = CMD_DRAIN;
        else
          cmd = CMD_PIXEL;
        px = ($urandom_range(99) < 85) ? pal[$urandom_range(pal_n - 1)] : pix_t'($urandom);
        send_word(cmd, px);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every accepted block, randomize ready
  // --------------------------------------------------------------------------
  initial begin
    blk_t got;
    blk_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && blk_if.valid && blk_if.ready) begin
        got.px[0] = blk_if.out_top_left;
        got.px[1] = blk_if.out_top_mid;
        got.px[2] = blk_if.out_top_right;
        got.px[3] = blk_if.out_mid_left;
        got.px[4] = blk_if.out_center;
        got.px[5] = blk_if.out_mid_right;
        got.px[6] = blk_if.out_bot_left;
        got.px[7] = blk_if.out_bot_mid;
        got.px[8] = blk_if.out_bot_right;
        got.col   = blk_if.src_col;
        got.row   = blk_if.src_row;
        got.last  = blk_if.run_last;
        sb.check_block(got);
      end
      blk_if.ready <= !rx_hold && ($urandom_range(99) >= idle_pct);
    end
  end

  // Long receiver stall: hold ready low while the sender keeps pushing, so
  // the internal queue fills and the block has to stall its input.
  initial begin
    rx_hold <= 1'b0;
    wait (press_arm);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Directed frame, 4 wide by 3 high: checkerboard corners, an early drain
    // at the end of row one and a pixel in the middle of the drain row.
    pix_t        dir_px [16] = '{8'h00, 8'hff, 8'h00, 8'h11,
                                 8'hff, 8'h00, 8'hff, 8'h11,
                                 8'h00, 8'hff, 8'h00, 8'hff,
                                 8'h5a, 8'ha5, 8'hff, 8'h3c};
    logic [15:0] dir_drain = 16'b1011_0000_1000_0000;
    logic [CFG_W-1:0] w_reg, h_reg;
    int unsigned sel, rand_base, guard;
    bit          press_now;

    rst_ni         <= 1'b0;
    pix_if.valid   <= 1'b0;
    pix_if.command <= CMD_PIXEL;
    pix_if.pixel   <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_IMAGE_WIDTH;
    cfg_if.data    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_reg(CFG_IMAGE_WIDTH, 11'd4);
    write_reg(CFG_IMAGE_HEIGHT, 11'd3);
    for (int k = 0; k < 16; k++)
      send_word(dir_drain[k] ? CMD_DRAIN : CMD_PIXEL, dir_px[k]);

    // Shrink the width mid-row, then cut the height below the current row.
    settle();
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    send_word(CMD_PIXEL, 8'h80);
    send_word(CMD_PIXEL, 8'h01);
    send_word(CMD_PIXEL, 8'h80);
    send_word(CMD_PIXEL, 8'h01);
    send_word(CMD_PIXEL, 8'h80);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 11'd0);   // zero acts as one column
    send_word(CMD_PIXEL, 8'h7f);         // past the new width: last column
    send_word(CMD_PIXEL, 8'hfe);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 11'd1);  // current row already beyond it
    send_word(CMD_DRAIN, 8'h00);

    // Out-of-range values saturate, so a short run stays inside row zero;
    // a shrink then makes the next word the last column of that row.
    settle();
    write_reg(CFG_IMAGE_WIDTH, 11'h7ff);
    write_reg(CFG_IMAGE_HEIGHT, 11'h7ff);
    for (int k = 0; k < 40; k++)
      send_word(CMD_PIXEL, pix_t'($urandom));
    settle();
    write_reg(CFG_IMAGE_WIDTH, 11'd4);
    write_reg(CFG_IMAGE_HEIGHT, 11'd2);
    send_word(CMD_PIXEL, 8'h33);
    for (int k = 0; k < 8; k++)
      send_word((k >= 4) ? CMD_DRAIN : CMD_PIXEL, pix_t'($urandom));

    // Random frames, mostly small; one of them carries the receiver stall.
    rand_base = words_sent;
    while (words_sent - rand_base < 1120) begin
      press_now = 1'b0;
      sel = $urandom_range(99);
      if (sel < 8)       w_reg = 11'd0;
      else if (sel < 14) w_reg = 11'd1;
      else if (sel < 90) w_reg = CFG_W'($urandom_range(12, 2));
      else               w_reg = CFG_W'($urandom_range(40, 13));
      sel = $urandom_range(99);
      if (sel < 6)       h_reg = 11'd0;
      else if (sel < 80) h_reg = CFG_W'($urandom_range(4, 1));
      else               h_reg = CFG_W'($urandom_range(8, 5));
      if (words_sent - rand_base >= 300 && !press_arm) begin
        w_reg = 11'd12;
        h_reg = 11'd6;
        press_now = 1'b1;
      end
      // Run back to back for a stretch, gaps elsewhere.
      idle_pct <= (words_sent - rand_base >= 500 && words_sent - rand_base < 800) ? 0 : 30;
      settle();
      if (press_now || $urandom_range(3) != 0) write_reg(CFG_IMAGE_WIDTH, w_reg);
      write_reg(CFG_IMAGE_HEIGHT, h_reg);
      // Start the receiver stall only once the frame is about to stream.
      if (press_now) press_arm = 1'b1;
      run_frame(5);
    end

    // Wait for the last owed block, with a bound, then let the pipe go quiet.
    pix_if.valid <= 1'b0;
    guard = 0;
    while (sb.pending_blocks.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.pending_blocks.size() != 0)
      sb.report_mismatch($sformatf("%0d blocks never arrived", sb.pending_blocks.size()));
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/pxu3_pkg.sv
rtl/pxu3_if.sv
rtl/pxu3_ram.sv
rtl/pxu3_front.sv
rtl/pxu3_queue.sv
rtl/pxu3_back.sv
rtl/pixel_art_upscale_3x.sv
tb/sv/tb_top.sv
